// ===== sv/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared constants and types for the cartridge bank mapper
// mapper kinds, register indexes, read-result selection and default sizes
// ----------------------------------------------------------------------------
package cbm_pkg;

   // default sizes, both powers of two
   localparam int RAM_BYTES_DEF     = 131072;
   localparam int MAX_ROM_BANKS_DEF = 512;

   // mapper kinds
   localparam logic [2:0] MAPPER_NONE = 3'd0;
   localparam logic [2:0] MAPPER_MBC1 = 3'd1;
   localparam logic [2:0] MAPPER_MBC2 = 3'd2;
   localparam logic [2:0] MAPPER_MBC3 = 3'd3;
   localparam logic [2:0] MAPPER_MBC5 = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_MAPPER_KIND   = 2'd0;
   localparam logic [1:0] CSR_RAM_PRESENT   = 2'd1;
   localparam logic [1:0] CSR_ROM_BANK_BITS = 2'd2;
   localparam logic [1:0] CSR_RAM_BANK_BITS = 2'd3;

   // bus operations
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // low nibble that enables cartridge ram
   localparam logic [3:0] RAM_ENABLE_CODE = 4'hA;

   // where the read byte of a result comes from
   typedef enum logic [1:0] {
      RD_ZERO,
      RD_ONES,
      RD_MEM
   } rd_sel_type;

   // item in flight between the memory read and the output register
   typedef struct packed {
      rd_sel_type  rd_sel;
      logic        rom_fetch;
      logic [22:0] rom_address;
   } stage_type;

endpackage

// ===== sv/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: rom/ram bank mapper for handheld console cartridges
// decodes cpu bus transfers for none, mbc1, mbc2, mbc3 and mbc5 mappers
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  req_     | in        | req_tvalid/req_tready  | op, address, data
//  rsp_     | out       | rsp_tvalid/rsp_tready  | read_data, rom_fetch, rom_address
//  csr_     | in        | csr_valid/csr_ready    | register index, write data
//
//  one request transfer per cycle while req_tready is high; after acceptance a result
//  is registered by the synchronous ram read, then by the output register
//  after reset all RAM_BYTES bytes of the ram (131072 by default) are filled with
//  0xff, one byte a cycle; req_tready stays low until the fill completes
//  a stalled rsp side is absorbed by the output register, so a new request is
//  still taken while one finished result waits
//  csr writes are taken in every cycle, fill included
//
module cartridge_bank_mapper
   import cbm_pkg::*;
#(
   parameter int RAM_BYTES     = RAM_BYTES_DEF,
   parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // op[0], address[16:1], data[24:17], zero[31:25]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_data[7:0], rom_fetch[8], rom_address[31:9]
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int         AW        = $clog2(RAM_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(RAM_BYTES - 1);
   localparam logic [8:0] ROM_LIMIT = 9'(MAX_ROM_BANKS - 1);

   // configuration registers
   logic [2:0] mapper_kind_ff;
   logic       ram_present_ff;
   logic [3:0] rom_bank_bits_ff;
   logic [2:0] ram_bank_bits_ff;

   // mapper state
   logic       ram_enable_ff,   ram_enable_in;
   logic [8:0] rom_bank_ff,     rom_bank_in;
   logic [3:0] ram_bank_ff,     ram_bank_in;
   logic       banking_mode_ff, banking_mode_in;
   logic       rtc_selected_ff, rtc_selected_in;

   // cartridge ram and its fill sweep
   logic [7:0]    cart_ram [RAM_BYTES];
   logic [7:0]    mem_rdata_ff;
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   // pipeline
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   logic      out_valid_ff;
   logic [7:0]  out_read_data_ff;
   logic        out_rom_fetch_ff;
   logic [22:0] out_rom_address_ff;

   // fields of the ram stage entry
   rd_sel_type  s1_rd_sel;
   logic        s1_rom_fetch;
   logic [22:0] s1_rom_address;

   // request fields
   logic        req_op;
   logic [15:0] req_address;
   logic [7:0]  req_data;

   logic req_acc, s1_adv, in_rom, in_ram;
   logic [3:0] rom_bits_eff;
   logic [2:0] ram_bits_eff;
   logic [8:0] rom_mask;
   logic [3:0] ram_mask;
   logic [8:0] bank_sel;
   logic [16:0] idx_full;
   logic [AW-1:0] ram_idx;
   logic        ram_wr;
   logic [7:0]  ram_wdata;
   logic [4:0]  bank5;
   logic [6:0]  bank7;
   logic [3:0]  bank4;
   logic [7:0]  read_byte;

   assign req_op      = req_tdata[0];
   assign req_address = req_tdata[16:1];
   assign req_data    = req_tdata[24:17];

   // handshakes
   assign csr_ready  = 1'b1;
   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req_acc    = req_tvalid && req_tready;

   // window decode
   assign in_rom = !req_address[15];
   assign in_ram = req_address[15:13] == 3'b101;

   // bank masks from the size registers
   assign rom_bits_eff = (rom_bank_bits_ff > 4'd9) ? 4'd9 : rom_bank_bits_ff;
   assign ram_bits_eff = (ram_bank_bits_ff > 3'd4) ? 3'd4 : ram_bank_bits_ff;
   assign rom_mask     = ~(9'h1FF << rom_bits_eff) & ROM_LIMIT;
   assign ram_mask     = ~(4'hF << ram_bits_eff);

   assign bank5 = (req_data[4:0] == 5'd0) ? 5'd1 : req_data[4:0];
   assign bank7 = (req_data[6:0] == 7'd0) ? 7'd1 : req_data[6:0];
   assign bank4 = (req_data[3:0] == 4'd0) ? 4'd1 : req_data[3:0];

   // mapper register writes
   always_comb begin
      ram_enable_in   = ram_enable_ff;
      rom_bank_in     = rom_bank_ff;
      ram_bank_in     = ram_bank_ff;
      banking_mode_in = banking_mode_ff;
      rtc_selected_in = rtc_selected_ff;
      if (req_acc && req_op == OP_WRITE && in_rom) begin
         unique case (mapper_kind_ff)
            MAPPER_MBC1: begin
               unique case (req_address[14:13])
                  2'd0: ram_enable_in = req_data[3:0] == RAM_ENABLE_CODE;
                  2'd1: rom_bank_in   = {4'd0, bank5};
                  2'd2: begin
                     if (!banking_mode_ff && req_data < 8'd4) begin
                        ram_bank_in = {2'd0, req_data[1:0]} & ram_mask;
                     end
                  end
                  default: banking_mode_in = req_data[0];
               endcase
            end
            MAPPER_MBC2: begin
               if (!req_address[14]) begin
                  if (req_address[8]) begin
                     rom_bank_in = {5'd0, bank4};
                  end else begin
                     ram_enable_in = req_data[3:0] == RAM_ENABLE_CODE;
                  end
               end
            end
            MAPPER_MBC3: begin
               unique case (req_address[14:13])
                  2'd0: ram_enable_in = req_data[3:0] == RAM_ENABLE_CODE;
                  2'd1: rom_bank_in   = {2'd0, bank7};
                  2'd2: begin
                     if (req_data > 8'd3) begin
                        rtc_selected_in = 1'b1;
                     end else begin
                        rtc_selected_in = 1'b0;
                        ram_bank_in     = {2'd0, req_data[1:0]} & ram_mask;
                     end
                  end
                  default: ;
               endcase
            end
            MAPPER_MBC5: begin
               unique case (req_address[14:12])
                  3'd0, 3'd1: ram_enable_in = req_data[3:0] == RAM_ENABLE_CODE;
                  3'd2:       rom_bank_in   = {rom_bank_ff[8], req_data};
                  3'd3:       rom_bank_in   = {req_data[0], rom_bank_ff[7:0]};
                  3'd4, 3'd5: begin
                     if (req_data < 8'h10) ram_bank_in = req_data[3:0] & ram_mask;
                  end
                  default: ;
               endcase
            end
            default: ;   // plain cartridge: register writes ignored
         endcase
      end
   end

   // ram index, write gating and read source
   always_comb begin
      idx_full  = {ram_bank_ff, req_address[12:0]};
      ram_wr    = 1'b0;
      ram_wdata = req_data;
      s1_rd_sel = RD_ZERO;
      unique case (mapper_kind_ff)
         MAPPER_MBC2: begin
            idx_full  = {8'd0, req_address[8:0]};
            ram_wr    = ram_enable_ff;
            ram_wdata = {4'd0, req_data[3:0]};
            s1_rd_sel = ram_enable_ff ? RD_MEM : RD_ONES;
         end
         MAPPER_MBC3: begin
            ram_wr = ram_enable_ff && ram_present_ff;
            if (!ram_enable_ff) begin
               s1_rd_sel = RD_ONES;
            end else begin
               s1_rd_sel = rtc_selected_ff ? RD_ZERO : RD_MEM;
            end
         end
         MAPPER_MBC1, MAPPER_MBC5: begin
            ram_wr = ram_enable_ff && ram_present_ff;
            s1_rd_sel = (ram_enable_ff && ram_present_ff) ? RD_MEM : RD_ONES;
         end
         default: begin
            idx_full  = {4'd0, req_address[12:0]};
            ram_wr    = 1'b1;
            s1_rd_sel = RD_MEM;
         end
      endcase
      ram_wr = ram_wr && req_acc && req_op == OP_WRITE && in_ram;
      if (!(req_op == OP_READ && in_ram)) s1_rd_sel = RD_ZERO;
   end

   assign ram_idx = idx_full[AW-1:0];

   // physical rom address for reads below 0x8000
   always_comb begin
      bank_sel = (mapper_kind_ff >= MAPPER_MBC1 && mapper_kind_ff <= MAPPER_MBC5) ?
                 rom_bank_ff : 9'd1;
      s1_rom_fetch   = req_op == OP_READ && in_rom;
      s1_rom_address = 23'd0;
      if (s1_rom_fetch) begin
         if (req_address[14]) begin
            s1_rom_address = {bank_sel & rom_mask, req_address[13:0]};
         end else begin
            s1_rom_address = {9'd0, req_address[13:0]};
         end
      end
   end

   assign s1_in = {s1_rd_sel, s1_rom_fetch, s1_rom_address};

   // cartridge ram: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         cart_ram[clr_addr_ff] <= 8'hFF;
      end else if (ram_wr) begin
         cart_ram[ram_idx] <= ram_wdata;
      end
      if (req_acc) begin
         mem_rdata_ff <= cart_ram[ram_idx];
      end
   end

   // fill sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == CLR_LAST) clearing_ff <= 1'b0;
      end
   end

   // configuration and mapper registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_kind_ff   <= MAPPER_NONE;
         ram_present_ff   <= 1'b0;
         rom_bank_bits_ff <= 4'd1;
         ram_bank_bits_ff <= 3'd0;
         ram_enable_ff    <= 1'b0;
         rom_bank_ff      <= 9'd1;
         ram_bank_ff      <= 4'd0;
         banking_mode_ff  <= 1'b0;
         rtc_selected_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MAPPER_KIND:   mapper_kind_ff   <= csr_data[2:0];
               CSR_RAM_PRESENT:   ram_present_ff   <= csr_data[0];
               CSR_ROM_BANK_BITS: rom_bank_bits_ff <= csr_data[3:0];
               default:           ram_bank_bits_ff <= csr_data[2:0];
            endcase
         end
         ram_enable_ff   <= ram_enable_in;
         rom_bank_ff     <= rom_bank_in;
         ram_bank_ff     <= ram_bank_in;
         banking_mode_ff <= banking_mode_in;
         rtc_selected_ff <= rtc_selected_in;
      end
   end

   // read byte picked once the ram data is back
   always_comb begin
      unique case (s1_ff.rd_sel)
         RD_MEM:  read_byte = mem_rdata_ff;
         RD_ONES: read_byte = 8'hFF;
         default: read_byte = 8'h00;
      endcase
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_acc) s1_ff <= s1_in;
      if (s1_valid_ff && s1_adv) begin
         out_read_data_ff   <= read_byte;
         out_rom_fetch_ff   <= s1_ff.rom_fetch;
         out_rom_address_ff <= s1_ff.rom_address;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_rom_address_ff, out_rom_fetch_ff, out_read_data_ff};

   // no transfer is in flight while the ram is being filled
   a_fill_empty: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !out_valid_ff)
      else $error("item in flight during ram fill");

   // an accepted request always occupies the ram stage next cycle
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted request lost");

   // both stages full with the output stalled must block new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken with pipeline full");

   // a rom fetch result carries no ram byte
   a_fetch_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rom_fetch_ff) |-> out_read_data_ff == 8'h00)
      else $error("rom fetch with nonzero read data");

endmodule
